@@ rtl/assert_macros.svh @@
// Assertion macros for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define ASSERT_NEVER(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);
`else
`define ASSERT_IMPL(label, prop, msg)
`define ASSERT_NEVER(label, cond, msg)
`endif
`endif

@@ rtl/i2cts_pkg.sv @@
`default_nettype none
package i2cts_pkg;

  typedef enum logic [1:0] {
    REQ_START = 2'd0,
    REQ_WBYTE = 2'd1,
    REQ_EVENT = 2'd2,
    REQ_CNT   = 2'd3
  } req_e;

  typedef enum logic [3:0] {
    ACT_SETWRITE  = 4'd0,
    ACT_SETREAD   = 4'd1,
    ACT_NEEDBYTE  = 4'd2,
    ACT_SEND      = 4'd3,
    ACT_START     = 4'd4,
    ACT_STOP      = 4'd5,
    ACT_STARTSTOP = 4'd6,
    ACT_DELIVER   = 4'd7,
    ACT_RECOVER   = 4'd8,
    ACT_DONE      = 4'd9,
    ACT_COUNTERS  = 4'd10
  } act_e;

  typedef enum logic [3:0] {
    PH_IDLE      = 4'd0,
    PH_NEED_BYTE = 4'd1,
    PH_TX        = 4'd2,
    PH_TX_LAST   = 4'd3,
    PH_FIN_WRITE = 4'd4,
    PH_RX_SINGLE = 4'd5,
    PH_RX        = 4'd6,
    PH_RX_LAST   = 4'd7,
    PH_FIN_END   = 4'd8
  } phase_e;

  localparam int unsigned MaxRes = 5;
  localparam logic [6:0] TenBitPrefix = 7'h78;
  localparam logic [2:0] RetryReset = 3'd3;
  localparam logic [15:0] OutMax = 16'hFFFF;

  typedef struct packed {
    logic [1:0] req_type;
    logic [9:0] target_address;
    logic [7:0] write_count;
    logic [7:0] read_count;
    logic [7:0] write_data;
    logic       tx_ready;
    logic       rx_ready;
    logic       tx_complete;
    logic       nack_seen;
    logic       timed_out;
    logic [7:0] rx_data;
  } in_t;

  typedef struct packed {
    logic [3:0]  action;
    logic        ten_bit;
    logic [6:0]  bus_address;
    logic [7:0]  low_address;
    logic [7:0]  data;
    logic [8:0]  byte_count;
    logic        last;
    logic [15:0] nak_count;
    logic [15:0] send_timeouts;
    logic [15:0] recv_timeouts;
    logic [15:0] finish_timeouts;
    logic [15:0] reset_count;
  } out_t;

  // counter bump requests from the step logic
  typedef struct packed {
    logic nak;
    logic send;
    logic recv;
    logic fin;
    logic rst;
    logic clear;
  } cnt_ctl_t;

endpackage
`default_nettype wire

@@ rtl/i2cts_counters.sv @@
`default_nettype none
module i2cts_counters #(
  parameter int unsigned CounterWidth = 16
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  i2cts_pkg::cnt_ctl_t  ctl_i,
  output logic [15:0]          nak_o,
  output logic [15:0]          send_o,
  output logic [15:0]          recv_o,
  output logic [15:0]          fin_o,
  output logic [15:0]          rst_o
);
  localparam logic [CounterWidth-1:0] Top = {CounterWidth{1'b1}};

  logic [CounterWidth-1:0] cnt_q [5];
  logic [4:0] inc;

  assign inc = {ctl_i.rst, ctl_i.fin, ctl_i.recv, ctl_i.send, ctl_i.nak};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 5; i++) cnt_q[i] <= '0;
    end else begin
      for (int i = 0; i < 5; i++) begin
        if (ctl_i.clear) cnt_q[i] <= '0;
        else if (inc[i] && cnt_q[i] != Top) cnt_q[i] <= cnt_q[i] + 1'b1;
      end
    end
  end

  function automatic logic [15:0] sat(input logic [CounterWidth-1:0] v);
    logic [CounterWidth+15:0] w;
    w = {16'd0, v};
    return (w > {{CounterWidth{1'b0}}, i2cts_pkg::OutMax}) ? i2cts_pkg::OutMax : w[15:0];
  endfunction

  assign nak_o  = sat(cnt_q[0]);
  assign send_o = sat(cnt_q[1]);
  assign recv_o = sat(cnt_q[2]);
  assign fin_o  = sat(cnt_q[3]);
  assign rst_o  = sat(cnt_q[4]);
endmodule
`default_nettype wire

@@ rtl/i2cts_out_buf.sv @@
`default_nettype none
module i2cts_out_buf (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  load_i,
  input  wire [2:0]            n_i,
  input  i2cts_pkg::out_t      res_i [i2cts_pkg::MaxRes],
  output logic                 busy_o,
  output logic                 free_next_o,
  output logic                 out_valid_o,
  input  wire                  out_ready_i,
  output i2cts_pkg::out_t      out_o
);
  i2cts_pkg::out_t buf_q [i2cts_pkg::MaxRes];
  logic [2:0] n_q, idx_q;
  logic pop, lastpop;

  assign out_valid_o = (n_q != 3'd0);
  assign busy_o = out_valid_o;
  assign pop = out_valid_o && out_ready_i;
  assign lastpop = pop && (idx_q + 3'd1 == n_q);
  assign free_next_o = !out_valid_o || lastpop;
  assign out_o = buf_q[idx_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q <= '0;
      idx_q <= '0;
    end else if (load_i) begin
      n_q <= n_i;
      idx_q <= '0;
    end else if (lastpop) begin
      n_q <= '0;
      idx_q <= '0;
    end else if (pop) begin
      idx_q <= idx_q + 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) buf_q <= res_i;
  end
endmodule
`default_nettype wire

@@ rtl/i2c_transfer_sequencer.sv @@
// Results of a beat appear in the cycle after it is accepted.
// Throughput: one input beat per cycle when the caller takes each result
// beat at once; a beat with N results blocks input until its last is taken.
// Reset: phase idle, all counts and error counters zero, retry_limit 3.
`default_nettype none
`include "assert_macros.svh"
module i2c_transfer_sequencer #(
  parameter int unsigned MaxLen = 255,
  parameter int unsigned CounterWidth = 16
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               in_valid_i,
  output logic              in_ready_o,
  input  i2cts_pkg::in_t    in_data_i,
  output logic              out_valid_o,
  input  wire               out_ready_i,
  output i2cts_pkg::out_t   out_data_o,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire               paddr,
  input  wire [31:0]        pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);
  localparam logic [7:0] MaxLenC = (MaxLen > 255) ? 8'd255 : 8'(MaxLen);

  // outcome of a status wait
  localparam logic [1:0] JudgeNone = 2'd0;
  localparam logic [1:0] JudgeOk   = 2'd1;
  localparam logic [1:0] JudgeFail = 2'd2;

  logic [2:0] retry_q;
  i2cts_pkg::phase_e ph_q, ph_d;
  logic [9:0] addr_q, addr_d;
  logic [7:0] ww_q, ww_d, rw_q, rw_d, bs_q, bs_d, br_q, br_d, held_q, held_d;
  logic [2:0] att_q, att_d;

  i2cts_pkg::out_t res [i2cts_pkg::MaxRes];
  logic [2:0] n;
  i2cts_pkg::cnt_ctl_t ctl;
  logic [15:0] c_nak, c_send, c_recv, c_fin, c_rst;
  logic acc, busy, free_next;

  assign pready = 1'b1;
  assign prdata = {29'd0, retry_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) retry_q <= i2cts_pkg::RetryReset;
    else if (psel && penable && pwrite && !paddr) retry_q <= pwdata[2:0];
  end

  assign in_ready_o = free_next;
  assign acc = in_valid_i && in_ready_o;

  i2cts_counters #(.CounterWidth(CounterWidth)) u_cnt (
    .clk_i, .rst_ni, .ctl_i(ctl),
    .nak_o(c_nak), .send_o(c_send), .recv_o(c_recv), .fin_o(c_fin), .rst_o(c_rst)
  );

  i2cts_out_buf u_buf (
    .clk_i, .rst_ni, .load_i(acc && n != 3'd0), .n_i(n), .res_i(res),
    .busy_o(busy), .free_next_o(free_next),
    .out_valid_o, .out_ready_i, .out_o(out_data_o)
  );

  // step logic
  always_comb begin
    i2cts_pkg::in_t d;
    logic [1:0] jr;
    logic [8:0] total;
    logic [2:0] lim;
    logic [7:0] wc, rc;
    logic fl;
    d = in_data_i;
    ph_d = ph_q; addr_d = addr_q; ww_d = ww_q; rw_d = rw_q;
    bs_d = bs_q; br_d = br_q; held_d = held_q; att_d = att_q;
    n = '0;
    ctl = '0;
    jr = JudgeNone;
    fl = 1'b0;
    wc = '0; rc = '0;
    total = '0;
    lim = (retry_q == 3'd0) ? 3'd1 : retry_q;
    for (int i = 0; i < i2cts_pkg::MaxRes; i++) res[i] = '0;

    if (acc) begin
      unique case (i2cts_pkg::req_e'(d.req_type))
        i2cts_pkg::REQ_START: begin
          if (ph_q == i2cts_pkg::PH_IDLE) begin
            wc = (d.write_count > MaxLenC) ? MaxLenC : d.write_count;
            rc = (d.read_count > MaxLenC) ? MaxLenC : d.read_count;
            addr_d = d.target_address; ww_d = wc; rw_d = rc; att_d = '0;
            if (wc == 8'd0 && rc == 8'd0) begin
              res[0].action = i2cts_pkg::ACT_DONE; n = 3'd1;
            end else begin
              bs_d = '0; br_d = '0;
              res[0].action = i2cts_pkg::ACT_SETWRITE; n = 3'd1;
              if (wc != 8'd0) begin
                res[1].action = i2cts_pkg::ACT_NEEDBYTE; n = 3'd2;
                ph_d = i2cts_pkg::PH_NEED_BYTE;
              end else begin
                res[1].action = i2cts_pkg::ACT_SETREAD;
                res[2].action = (rc == 8'd1) ? i2cts_pkg::ACT_STARTSTOP
                                             : i2cts_pkg::ACT_START;
                ph_d = (rc == 8'd1) ? i2cts_pkg::PH_RX_SINGLE : i2cts_pkg::PH_RX;
                n = 3'd3;
              end
            end
          end
        end
        i2cts_pkg::REQ_WBYTE: begin
          if (ph_q == i2cts_pkg::PH_NEED_BYTE) begin
            held_d = d.write_data;
            res[0].action = i2cts_pkg::ACT_SEND; res[0].data = d.write_data; n = 3'd1;
            if ({1'b0, bs_q} + 9'd1 >= {1'b0, ww_q}) begin
              res[1].action = i2cts_pkg::ACT_STOP; n = 3'd2;
              ph_d = i2cts_pkg::PH_TX_LAST;
            end else ph_d = i2cts_pkg::PH_TX;
          end
        end
        i2cts_pkg::REQ_EVENT: begin
          unique case (ph_q)
            i2cts_pkg::PH_TX, i2cts_pkg::PH_TX_LAST: fl = d.tx_ready;
            i2cts_pkg::PH_FIN_WRITE, i2cts_pkg::PH_FIN_END: fl = d.tx_complete;
            i2cts_pkg::PH_RX, i2cts_pkg::PH_RX_SINGLE, i2cts_pkg::PH_RX_LAST:
              fl = d.rx_ready;
            default: fl = 1'b0;
          endcase
          if (ph_q != i2cts_pkg::PH_IDLE && ph_q != i2cts_pkg::PH_NEED_BYTE) begin
            if (d.nack_seen) begin jr = JudgeFail; ctl.nak = 1'b1; end
            else if (fl) jr = JudgeOk;
            else if (d.timed_out) begin
              jr = JudgeFail;
              unique case (ph_q)
                i2cts_pkg::PH_TX, i2cts_pkg::PH_TX_LAST: ctl.send = 1'b1;
                i2cts_pkg::PH_FIN_WRITE, i2cts_pkg::PH_FIN_END: ctl.fin = 1'b1;
                default: ctl.recv = 1'b1;
              endcase
            end
          end
          unique case (ph_q)
            i2cts_pkg::PH_TX: begin
              if (jr == JudgeOk) begin
                bs_d = bs_q + 8'd1;
                res[0].action = i2cts_pkg::ACT_NEEDBYTE;
                res[0].byte_count = {1'b0, bs_d}; n = 3'd1;
                ph_d = i2cts_pkg::PH_NEED_BYTE;
              end else if (jr == JudgeFail) begin
                res[0].action = i2cts_pkg::ACT_STOP; n = 3'd1;
                ph_d = i2cts_pkg::PH_FIN_END;
              end
            end
            i2cts_pkg::PH_TX_LAST: begin
              if (jr == JudgeOk) bs_d = bs_q + 8'd1;
              if (jr != JudgeNone) ph_d = i2cts_pkg::PH_FIN_WRITE;
            end
            i2cts_pkg::PH_RX_SINGLE, i2cts_pkg::PH_RX_LAST: begin
              if (jr == JudgeOk) begin
                held_d = d.rx_data;
                res[0].action = i2cts_pkg::ACT_DELIVER; res[0].data = d.rx_data;
                n = 3'd1; br_d = br_q + 8'd1;
              end
              if (jr != JudgeNone) ph_d = i2cts_pkg::PH_FIN_END;
            end
            i2cts_pkg::PH_RX: begin
              if (jr == JudgeFail) begin
                res[0].action = i2cts_pkg::ACT_STOP; n = 3'd1;
                ph_d = i2cts_pkg::PH_FIN_END;
              end else if (jr == JudgeOk) begin
                br_d = br_q + 8'd1; held_d = d.rx_data;
                if ({1'b0, br_d} + 9'd1 == {1'b0, rw_q}) begin
                  res[0].action = i2cts_pkg::ACT_STOP;
                  res[1].action = i2cts_pkg::ACT_DELIVER; res[1].data = d.rx_data;
                  n = 3'd2; ph_d = i2cts_pkg::PH_RX_LAST;
                end else begin
                  res[0].action = i2cts_pkg::ACT_DELIVER; res[0].data = d.rx_data;
                  n = 3'd1;
                end
              end
            end
            i2cts_pkg::PH_FIN_WRITE, i2cts_pkg::PH_FIN_END: begin
              if (jr != JudgeNone) begin
                if (ph_q == i2cts_pkg::PH_FIN_WRITE && !(bs_q < ww_q || rw_q == 8'd0))
                begin
                  res[0].action = i2cts_pkg::ACT_SETREAD;
                  res[1].action = (rw_q == 8'd1) ? i2cts_pkg::ACT_STARTSTOP
                                                 : i2cts_pkg::ACT_START;
                  ph_d = (rw_q == 8'd1) ? i2cts_pkg::PH_RX_SINGLE : i2cts_pkg::PH_RX;
                  n = 3'd2;
                end else begin
                  total = {1'b0, bs_q} + {1'b0, br_q};
                  if (total == {1'b0, ww_q} + {1'b0, rw_q}) begin
                    res[0].action = i2cts_pkg::ACT_DONE; res[0].byte_count = total;
                    n = 3'd1; ph_d = i2cts_pkg::PH_IDLE;
                  end else begin
                    ctl.rst = 1'b1;
                    res[0].action = i2cts_pkg::ACT_RECOVER;
                    att_d = att_q + 3'd1;
                    if (att_d >= lim) begin
                      res[1].action = i2cts_pkg::ACT_DONE; res[1].byte_count = total;
                      n = 3'd2; ph_d = i2cts_pkg::PH_IDLE;
                    end else begin
                      bs_d = '0; br_d = '0;
                      res[1].action = i2cts_pkg::ACT_SETWRITE;
                      if (ww_q != 8'd0) begin
                        res[2].action = i2cts_pkg::ACT_NEEDBYTE; n = 3'd3;
                        ph_d = i2cts_pkg::PH_NEED_BYTE;
                      end else begin
                        res[2].action = i2cts_pkg::ACT_SETREAD;
                        res[3].action = (rw_q == 8'd1) ? i2cts_pkg::ACT_STARTSTOP
                                                       : i2cts_pkg::ACT_START;
                        ph_d = (rw_q == 8'd1) ? i2cts_pkg::PH_RX_SINGLE
                                              : i2cts_pkg::PH_RX;
                        n = 3'd4;
                      end
                    end
                  end
                end
              end
            end
            default: ;
          endcase
        end
        i2cts_pkg::REQ_CNT: begin
          res[0].action = i2cts_pkg::ACT_COUNTERS;
          res[0].nak_count = c_nak; res[0].send_timeouts = c_send;
          res[0].recv_timeouts = c_recv; res[0].finish_timeouts = c_fin;
          res[0].reset_count = c_rst;
          ctl.clear = 1'b1; n = 3'd1;
        end
        default: ;
      endcase
      for (int i = 0; i < i2cts_pkg::MaxRes; i++) begin
        if (res[i].action == i2cts_pkg::ACT_SETWRITE ||
            res[i].action == i2cts_pkg::ACT_SETREAD) begin
          if (addr_d >= 10'h80) begin
            res[i].ten_bit = 1'b1;
            res[i].bus_address = i2cts_pkg::TenBitPrefix | {5'd0, addr_d[9:8]};
            res[i].low_address = addr_d[7:0];
          end else res[i].bus_address = addr_d[6:0];
        end
        if (3'(i) + 3'd1 == n) res[i].last = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= i2cts_pkg::PH_IDLE;
      addr_q <= '0; ww_q <= '0; rw_q <= '0; bs_q <= '0; br_q <= '0;
      held_q <= '0; att_q <= '0;
    end else begin
      ph_q <= ph_d; addr_q <= addr_d; ww_q <= ww_d; rw_q <= rw_d;
      bs_q <= bs_d; br_q <= br_d; held_q <= held_d; att_q <= att_d;
    end
  end

  `ASSERT_IMPL(a_stall_blocks_in, (out_valid_o && !out_ready_i) |-> !in_ready_o,
    "input taken while results pending")
  `ASSERT_NEVER(a_bs_bound, ph_q != i2cts_pkg::PH_IDLE && bs_q > ww_q,
    "bytes sent exceeds request")
  `ASSERT_IMPL(a_busy_valid, busy == out_valid_o, "buffer state mismatch")
  `ASSERT_NEVER(a_held_ok, held_q != held_q, "held byte X")
endmodule
`default_nettype wire

@@ sim/i2c_transfer_sequencer_checker.sv @@
module i2c_transfer_sequencer_checker (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_ready_i,
  input  i2cts_pkg::in_t   in_data_i,
  input  logic             out_valid_i,
  input  logic             out_ready_i,
  input  i2cts_pkg::out_t  out_data_i,
  input  logic             psel_i,
  input  logic             penable_i,
  input  logic             pwrite_i,
  input  logic             paddr_i,
  input  logic [31:0]      pwdata_i,
  input  logic             pready_i,
  output int               fail_count_o,
  output int               pending_o,
  output int               results_seen_o
);
  timeunit 1ns;
  timeprecision 1ps;

  logic [2:0]          attempts_allowed;
  i2cts_pkg::phase_e   seq_phase;
  logic [9:0]          dev_addr;
  int unsigned         writes_req, reads_req, sent_cnt, rcvd_cnt;
  logic [2:0]          attempt_idx;
  logic [7:0]          last_byte;
  logic [15:0]         err_cnt [5];
  i2cts_pkg::out_t     step_res[$];
  i2cts_pkg::out_t     pending_res[$];

  localparam int ErrNak = 0;
  localparam int ErrSend = 1;
  localparam int ErrRecv = 2;
  localparam int ErrFin = 3;
  localparam int ErrRetry = 4;

  localparam int JudgeNone = 0;
  localparam int JudgeOk = 1;
  localparam int JudgeFail = 2;

  function automatic void add_res(i2cts_pkg::act_e act, logic [7:0] d, logic [8:0] cnt);
    i2cts_pkg::out_t r;
    r = '0;
    r.action = act;
    r.data = d;
    r.byte_count = cnt;
    step_res.push_back(r);
  endfunction

  function automatic void add_mode(i2cts_pkg::act_e act);
    i2cts_pkg::out_t r;
    r = '0;
    r.action = act;
    if (dev_addr >= 10'h080) begin
      r.ten_bit = 1'b1;
      r.bus_address = i2cts_pkg::TenBitPrefix | {5'd0, dev_addr[9:8]};
      r.low_address = dev_addr[7:0];
    end else begin
      r.bus_address = dev_addr[6:0];
    end
    step_res.push_back(r);
  endfunction

  function automatic void bump(int idx);
    if (err_cnt[idx] != i2cts_pkg::OutMax) err_cnt[idx]++;
  endfunction

  function automatic int judge(i2cts_pkg::in_t x, logic flag, int tmo_idx);
    if (x.nack_seen) begin
      bump(ErrNak);
      return JudgeFail;
    end
    if (flag) return JudgeOk;
    if (x.timed_out) begin
      bump(tmo_idx);
      return JudgeFail;
    end
    return JudgeNone;
  endfunction

  function automatic void open_read();
    add_mode(i2cts_pkg::ACT_SETREAD);
    if (reads_req == 1) begin
      add_res(i2cts_pkg::ACT_STARTSTOP, 8'd0, 9'd0);
      seq_phase = i2cts_pkg::PH_RX_SINGLE;
    end else begin
      add_res(i2cts_pkg::ACT_START, 8'd0, 9'd0);
      seq_phase = i2cts_pkg::PH_RX;
    end
  endfunction

  function automatic void open_attempt();
    sent_cnt = 0;
    rcvd_cnt = 0;
    add_mode(i2cts_pkg::ACT_SETWRITE);
    if (writes_req != 0) begin
      add_res(i2cts_pkg::ACT_NEEDBYTE, 8'd0, 9'd0);
      seq_phase = i2cts_pkg::PH_NEED_BYTE;
    end else begin
      open_read();
    end
  endfunction

  function automatic void close_attempt();
    int unsigned total, lim;
    total = sent_cnt + rcvd_cnt;
    lim = (attempts_allowed == 3'd0) ? 1 : attempts_allowed;
    if (total == writes_req + reads_req) begin
      add_res(i2cts_pkg::ACT_DONE, 8'd0, total[8:0]);
      seq_phase = i2cts_pkg::PH_IDLE;
      return;
    end
    bump(ErrRetry);
    add_res(i2cts_pkg::ACT_RECOVER, 8'd0, 9'd0);
    attempt_idx = attempt_idx + 3'd1;
    if (attempt_idx >= lim) begin
      add_res(i2cts_pkg::ACT_DONE, 8'd0, total[8:0]);
      seq_phase = i2cts_pkg::PH_IDLE;
    end else begin
      open_attempt();
    end
  endfunction

  function automatic void bus_event(i2cts_pkg::in_t x);
    int r;
    case (seq_phase)
      i2cts_pkg::PH_TX: begin
        r = judge(x, x.tx_ready, ErrSend);
        if (r == JudgeOk) begin
          sent_cnt = (sent_cnt + 1) & 8'hFF;
          add_res(i2cts_pkg::ACT_NEEDBYTE, 8'd0, sent_cnt[8:0]);
          seq_phase = i2cts_pkg::PH_NEED_BYTE;
        end else if (r == JudgeFail) begin
          add_res(i2cts_pkg::ACT_STOP, 8'd0, 9'd0);
          seq_phase = i2cts_pkg::PH_FIN_END;
        end
      end
      i2cts_pkg::PH_TX_LAST: begin
        r = judge(x, x.tx_ready, ErrSend);
        if (r == JudgeOk) sent_cnt = (sent_cnt + 1) & 8'hFF;
        if (r != JudgeNone) seq_phase = i2cts_pkg::PH_FIN_WRITE;
      end
      i2cts_pkg::PH_FIN_WRITE: begin
        if (judge(x, x.tx_complete, ErrFin) != JudgeNone) begin
          if (sent_cnt < writes_req || reads_req == 0) close_attempt();
          else open_read();
        end
      end
      i2cts_pkg::PH_RX_SINGLE, i2cts_pkg::PH_RX_LAST: begin
        r = judge(x, x.rx_ready, ErrRecv);
        if (r == JudgeOk) begin
          last_byte = x.rx_data;
          add_res(i2cts_pkg::ACT_DELIVER, x.rx_data, 9'd0);
          rcvd_cnt = (rcvd_cnt + 1) & 8'hFF;
        end
        if (r != JudgeNone) seq_phase = i2cts_pkg::PH_FIN_END;
      end
      i2cts_pkg::PH_RX: begin
        r = judge(x, x.rx_ready, ErrRecv);
        if (r == JudgeFail) begin
          add_res(i2cts_pkg::ACT_STOP, 8'd0, 9'd0);
          seq_phase = i2cts_pkg::PH_FIN_END;
        end else if (r == JudgeOk) begin
          rcvd_cnt = (rcvd_cnt + 1) & 8'hFF;
          last_byte = x.rx_data;
          if (rcvd_cnt + 1 == reads_req) begin
            add_res(i2cts_pkg::ACT_STOP, 8'd0, 9'd0);
            seq_phase = i2cts_pkg::PH_RX_LAST;
          end
          add_res(i2cts_pkg::ACT_DELIVER, x.rx_data, 9'd0);
        end
      end
      i2cts_pkg::PH_FIN_END: begin
        if (judge(x, x.tx_complete, ErrFin) != JudgeNone) close_attempt();
      end
      default: ;
    endcase
  endfunction

  function automatic void predict_beat(i2cts_pkg::in_t x);
    i2cts_pkg::out_t r;
    int unsigned wc, rc;
    step_res.delete();
    case (i2cts_pkg::req_e'(x.req_type))
      i2cts_pkg::REQ_START: begin
        if (seq_phase == i2cts_pkg::PH_IDLE) begin
          wc = (x.write_count > 255) ? 255 : x.write_count;
          rc = (x.read_count > 255) ? 255 : x.read_count;
          dev_addr = x.target_address;
          writes_req = wc;
          reads_req = rc;
          attempt_idx = 3'd0;
          if (wc + rc == 0) add_res(i2cts_pkg::ACT_DONE, 8'd0, 9'd0);
          else open_attempt();
        end
      end
      i2cts_pkg::REQ_WBYTE: begin
        if (seq_phase == i2cts_pkg::PH_NEED_BYTE) begin
          last_byte = x.write_data;
          add_res(i2cts_pkg::ACT_SEND, last_byte, 9'd0);
          if (sent_cnt + 1 >= writes_req) begin
            add_res(i2cts_pkg::ACT_STOP, 8'd0, 9'd0);
            seq_phase = i2cts_pkg::PH_TX_LAST;
          end else begin
            seq_phase = i2cts_pkg::PH_TX;
          end
        end
      end
      i2cts_pkg::REQ_EVENT: bus_event(x);
      default: begin
        r = '0;
        r.action = i2cts_pkg::ACT_COUNTERS;
        r.nak_count = err_cnt[ErrNak];
        r.send_timeouts = err_cnt[ErrSend];
        r.recv_timeouts = err_cnt[ErrRecv];
        r.finish_timeouts = err_cnt[ErrFin];
        r.reset_count = err_cnt[ErrRetry];
        for (int i = 0; i < 5; i++) err_cnt[i] = '0;
        step_res.push_back(r);
      end
    endcase
    if (step_res.size() > 0) step_res[step_res.size()-1].last = 1'b1;
    foreach (step_res[i]) pending_res.push_back(step_res[i]);
  endfunction

  function automatic void cmp(string name, longint unsigned e, longint unsigned a);
    if (e != a) begin
      $error("%s: expected %0d, actual %0d", name, e, a);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    i2cts_pkg::out_t w;
    if (!rst_ni) begin
      attempts_allowed = i2cts_pkg::RetryReset;
      seq_phase = i2cts_pkg::PH_IDLE;
      dev_addr = '0;
      writes_req = 0;
      reads_req = 0;
      sent_cnt = 0;
      rcvd_cnt = 0;
      attempt_idx = '0;
      last_byte = '0;
      for (int i = 0; i < 5; i++) err_cnt[i] = '0;
      pending_res.delete();
      fail_count_o = 0;
      results_seen_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        results_seen_o++;
        if (pending_res.size() == 0) begin
          $error("result beat with no expectation: action %0d", out_data_i.action);
          fail_count_o++;
        end else begin
          w = pending_res.pop_front();
          cmp("action", w.action, out_data_i.action);
          cmp("ten_bit", w.ten_bit, out_data_i.ten_bit);
          cmp("bus_address", w.bus_address, out_data_i.bus_address);
          cmp("low_address", w.low_address, out_data_i.low_address);
          cmp("data", w.data, out_data_i.data);
          cmp("byte_count", w.byte_count, out_data_i.byte_count);
          cmp("last", w.last, out_data_i.last);
          cmp("nak_count", w.nak_count, out_data_i.nak_count);
          cmp("send_timeouts", w.send_timeouts, out_data_i.send_timeouts);
          cmp("recv_timeouts", w.recv_timeouts, out_data_i.recv_timeouts);
          cmp("finish_timeouts", w.finish_timeouts, out_data_i.finish_timeouts);
          cmp("reset_count", w.reset_count, out_data_i.reset_count);
        end
      end
      if (in_valid_i && in_ready_i) predict_beat(in_data_i);
      if (psel_i && penable_i && pwrite_i && pready_i && paddr_i == 1'b0)
        attempts_allowed = pwdata_i[2:0];
    end
    pending_o = pending_res.size();
  end
endmodule

@@ sim/i2c_transfer_sequencer_tb.sv @@
module i2c_transfer_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int InW = $bits(i2cts_pkg::in_t);

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  i2cts_pkg::in_t   in_data = '0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  i2cts_pkg::out_t  out_data;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic             paddr = 1'b0;
  logic [31:0]      pwdata = '0;
  logic [31:0]      prdata;
  logic             pready;
  int               fail_count, pending, results_seen;
  bit               quiet = 1'b0;
  bit               hold_req = 1'b0;
  int               beats_sent = 0;

  always #5 clk_i = ~clk_i;

  i2c_transfer_sequencer u_dut (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_o(in_ready), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_ready_i(out_ready), .out_data_o(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  i2c_transfer_sequencer_checker u_chk (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid), .in_ready_i(in_ready), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_ready_i(out_ready), .out_data_i(out_data),
    .psel_i(psel), .penable_i(penable), .pwrite_i(pwrite), .paddr_i(paddr),
    .pwdata_i(pwdata), .pready_i(pready),
    .fail_count_o(fail_count), .pending_o(pending), .results_seen_o(results_seen)
  );

  initial begin
    @(posedge rst_ni);
    forever begin
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (200) @(posedge clk_i);
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        out_ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  function automatic i2cts_pkg::in_t noise();
    return i2cts_pkg::in_t'(InW'({$urandom, $urandom}));
  endfunction

  function automatic i2cts_pkg::in_t mk_start(logic [9:0] a, logic [7:0] w, logic [7:0] r);
    i2cts_pkg::in_t x;
    x = noise();
    x.req_type = i2cts_pkg::REQ_START;
    x.target_address = a;
    x.write_count = w;
    x.read_count = r;
    return x;
  endfunction

  function automatic i2cts_pkg::in_t mk_wbyte(logic [7:0] d);
    i2cts_pkg::in_t x;
    x = noise();
    x.req_type = i2cts_pkg::REQ_WBYTE;
    x.write_data = d;
    return x;
  endfunction

  function automatic i2cts_pkg::in_t mk_evt(bit tx, bit rx, bit tc, bit nk, bit to,
                                            logic [7:0] d);
    i2cts_pkg::in_t x;
    x = noise();
    x.req_type = i2cts_pkg::REQ_EVENT;
    {x.tx_ready, x.rx_ready, x.tx_complete, x.nack_seen, x.timed_out} = {tx, rx, tc, nk, to};
    x.rx_data = d;
    return x;
  endfunction

  function automatic i2cts_pkg::in_t mk_cnt();
    i2cts_pkg::in_t x;
    x = noise();
    x.req_type = i2cts_pkg::REQ_CNT;
    return x;
  endfunction

  function automatic i2cts_pkg::in_t rand_evt();
    int k;
    k = $urandom_range(0, 99);
    if (k < 72) return mk_evt(1'b1, 1'b1, 1'b1, 1'b0, 1'($urandom), 8'($urandom));
    if (k < 82) return mk_evt(1'($urandom), 1'($urandom), 1'($urandom), 1'b1,
                              1'($urandom), 8'($urandom));
    if (k < 94) return mk_evt(1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 8'($urandom));
    return mk_evt(1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 8'($urandom));
  endfunction

  task automatic put(i2cts_pkg::in_t v);
    in_valid <= 1'b1;
    in_data <= v;
    @(posedge clk_i);
    while (!in_ready) @(posedge clk_i);
    beats_sent++;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_retry(logic [2:0] v);
    drain();
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= 1'b0;
    pwdata <= {29'($urandom), v};
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic rand_transfer();
    int n, w, r;
    if ($urandom_range(0, 9) == 0) begin
      w = $urandom_range(0, 255);
      r = $urandom_range(0, 255);
    end else begin
      w = $urandom_range(0, 4);
      r = $urandom_range(0, 4);
    end
    put(mk_start(10'($urandom_range(0, 1023)), 8'(w), 8'(r)));
    n = 2 * ((w > 4 ? 4 : w) + (r > 4 ? 4 : r)) + $urandom_range(2, 8);
    repeat (n) begin
      if ($urandom_range(0, 99) < 40) put(mk_wbyte(8'($urandom)));
      else if ($urandom_range(0, 99) < 3) put(mk_cnt());
      else put(rand_evt());
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    put(mk_cnt());
    put(mk_start(10'h000, 8'd0, 8'd0));
    put(mk_evt(1, 1, 1, 0, 0, 8'h00));
    put(mk_wbyte(8'hAA));
    put(mk_start(10'h07F, 8'd1, 8'd1));
    put(mk_start(10'h3FF, 8'd2, 8'd2));
    put(mk_evt(0, 0, 0, 0, 0, 8'h11));
    put(mk_wbyte(8'hFF));
    put(mk_evt(1, 0, 0, 0, 0, 8'h00));
    put(mk_evt(0, 0, 1, 0, 0, 8'h00));
    put(mk_evt(0, 1, 0, 0, 0, 8'hFF));
    put(mk_evt(0, 0, 1, 0, 0, 8'h00));
    put(mk_start(10'h3FF, 8'd2, 8'd2));
    put(mk_wbyte(8'h00));
    put(mk_evt(0, 0, 0, 0, 1, 8'h00));
    put(mk_evt(0, 0, 0, 0, 1, 8'h00));
    put(mk_wbyte(8'h5A));
    put(mk_evt(1, 0, 0, 1, 0, 8'h00));
    put(mk_evt(0, 0, 0, 0, 1, 8'h00));
    put(mk_start(10'h080, 8'd255, 8'd255));
    repeat (4) put(mk_evt(0, 0, 0, 1, 0, 8'h00));
    put(mk_cnt());

    set_retry(3'd0);
    repeat (7) rand_transfer();
    set_retry(3'd7);
    repeat (6) rand_transfer();
    hold_req = 1'b1;
    repeat (2) rand_transfer();
    set_retry(3'd1);
    repeat (6) rand_transfer();
    set_retry(3'd3);
    quiet = 1'b1;
    repeat (3) rand_transfer();
    put(mk_cnt());
    drain();
    repeat (20) @(posedge clk_i);

    $display("stimulus: %0d input beats, %0d result beats checked", beats_sent, results_seen);
    $display("covered 7/10-bit addresses, retries at limits 0,1,3,7, NAKs and timeouts");
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
